/* rtl/msps_pkg.sv */
package msps_pkg;

  localparam int DATA_W    = 32;
  localparam int IDX_W     = 3;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_ROWS_DEF = 8;
  localparam int MAX_COLS_DEF = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ROW_START,
    ST_ROW_SCAN,
    ST_COL_START,
    ST_COL_SCAN,
    ST_CHECK
  } state_e;

  typedef struct packed {
    logic load;        // store an accepted element
    logic start_row;   // begin row-maximum scan of current row
    logic start_col;   // begin column-minimum scan of current column
    logic clr_col;
    logic next_col;
    logic next_row;
    logic emit;        // load output register, restart loading
    logic emit_found;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_elem;
    logic scan_done;
    logic is_saddle;
    logic last_col;
    logic last_row;
    logic slot_free;
  } dp_status_t;

endpackage

/* rtl/msps_ctrl.sv */
module msps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  msps_pkg::dp_status_t status_i,
  output msps_pkg::ctrl_cmd_t  cmd_o
);

  msps_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msps_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      msps_pkg::ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.last_elem) state_d = msps_pkg::ST_ROW_START;
        end
      end
      msps_pkg::ST_ROW_START: begin
        cmd_o.start_row = 1'b1;
        state_d         = msps_pkg::ST_ROW_SCAN;
      end
      msps_pkg::ST_ROW_SCAN: begin
        if (status_i.scan_done) begin
          cmd_o.clr_col = 1'b1;
          state_d       = msps_pkg::ST_COL_START;
        end
      end
      msps_pkg::ST_COL_START: begin
        cmd_o.start_col = 1'b1;
        state_d         = msps_pkg::ST_COL_SCAN;
      end
      msps_pkg::ST_COL_SCAN: begin
        if (status_i.scan_done) state_d = msps_pkg::ST_CHECK;
      end
      msps_pkg::ST_CHECK: begin
        // a final result waits here until the output register can take it
        if (status_i.is_saddle) begin
          if (status_i.slot_free) begin
            cmd_o.emit       = 1'b1;
            cmd_o.emit_found = 1'b1;
            state_d          = msps_pkg::ST_LOAD;
          end
        end else if (!status_i.last_col) begin
          cmd_o.next_col = 1'b1;
          state_d        = msps_pkg::ST_COL_START;
        end else if (!status_i.last_row) begin
          cmd_o.next_row = 1'b1;
          state_d        = msps_pkg::ST_ROW_START;
        end else if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = msps_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = msps_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

/* rtl/msps_datapath.sv */
module msps_datapath #(
  parameter int MAX_ROWS = msps_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = msps_pkg::MAX_COLS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [msps_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [msps_pkg::CFG_W-1:0]              cfg_data_i,
  input  logic signed [msps_pkg::DATA_W-1:0]      element_i,
  input  logic                                    out_stall_i,
  output logic                                    out_valid_o,
  output logic                                    found_o,
  output logic [msps_pkg::IDX_W-1:0]              row_index_o,
  output logic [msps_pkg::IDX_W-1:0]              col_index_o,
  input  msps_pkg::ctrl_cmd_t                     cmd_i,
  output msps_pkg::dp_status_t                    status_o
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int KW    = (RW > CW) ? RW : CW;
  localparam int PW    = RW + CW;
  localparam int TW    = (PW > CNT_W) ? PW : CNT_W;

  logic signed [msps_pkg::DATA_W-1:0] mem [DEPTH];

  logic [RW-1:0]    rows_q, row_wr;
  logic [CW-1:0]    cols_q, col_wr;
  logic [CNT_W-1:0] load_cnt_q;
  logic [TW-1:0]    target, cnt_next;

  logic [AW-1:0] addr_q, step_q, row_base_q;
  logic [KW-1:0] cnt_q, k_q, rd_k_q;
  logic          col_mode_q, issue;
  logic          rd_valid_q, rd_first_q, rd_col_q;
  logic signed [msps_pkg::DATA_W-1:0] rd_data_q, rmax_q, cmin_q, v_q;

  logic [RW-1:0] r_q;
  logic [CW-1:0] c_q;

  logic                         out_valid_q, found_q;
  logic [msps_pkg::IDX_W-1:0]   row_q, col_q;

  // config writes saturate into 1..max
  always_comb begin
    if (cfg_data_i == '0) begin
      row_wr = RW'(1);
      col_wr = CW'(1);
    end else begin
      row_wr = (int'(cfg_data_i) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(cfg_data_i);
      col_wr = (int'(cfg_data_i) > MAX_COLS) ? CW'(MAX_COLS) : CW'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RW'(MAX_ROWS);
      cols_q <= CW'(MAX_COLS);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == msps_pkg::REG_ROW_COUNT) rows_q <= row_wr;
      if (cfg_idx_i == msps_pkg::REG_COL_COUNT) cols_q <= col_wr;
    end
  end

  assign target   = TW'(rows_q) * TW'(cols_q);
  assign cnt_next = TW'(load_cnt_q) + TW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
    end else if (cmd_i.emit) begin
      load_cnt_q <= '0;
    end else if (cmd_i.load && (TW'(load_cnt_q) < TW'(DEPTH))) begin
      load_cnt_q <= CNT_W'(cnt_next);
    end
  end

  // address walker: unit stride along a row, stride cols down a column
  assign issue = (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q     <= '0;
      step_q     <= '0;
      cnt_q      <= '0;
      k_q        <= '0;
      col_mode_q <= 1'b0;
      rd_valid_q <= 1'b0;
      rd_first_q <= 1'b0;
      rd_col_q   <= 1'b0;
      rd_k_q     <= '0;
    end else begin
      rd_valid_q <= issue;
      rd_first_q <= (k_q == '0);
      rd_col_q   <= col_mode_q;
      rd_k_q     <= k_q;
      if (cmd_i.start_row) begin
        addr_q     <= row_base_q;
        step_q     <= AW'(1);
        cnt_q      <= KW'(cols_q);
        k_q        <= '0;
        col_mode_q <= 1'b0;
      end else if (cmd_i.start_col) begin
        addr_q     <= AW'(c_q);
        step_q     <= AW'(cols_q);
        cnt_q      <= KW'(rows_q);
        k_q        <= '0;
        col_mode_q <= 1'b1;
      end else if (issue) begin
        addr_q <= addr_q + step_q;
        cnt_q  <= cnt_q - KW'(1);
        k_q    <= k_q + KW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (TW'(load_cnt_q) < TW'(DEPTH))) begin
      mem[load_cnt_q[AW-1:0]] <= element_i;
    end
    if (issue) begin
      rd_data_q <= mem[addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_valid_q) begin
      if (!rd_col_q) begin
        if (rd_first_q || (rd_data_q > rmax_q)) rmax_q <= rd_data_q;
      end else begin
        if (rd_first_q || (rd_data_q < cmin_q)) cmin_q <= rd_data_q;
        if (rd_k_q == KW'(r_q)) v_q <= rd_data_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q        <= '0;
      c_q        <= '0;
      row_base_q <= '0;
    end else begin
      if (cmd_i.emit) begin
        r_q        <= '0;
        row_base_q <= '0;
      end else if (cmd_i.next_row) begin
        r_q        <= r_q + RW'(1);
        row_base_q <= row_base_q + AW'(cols_q);
      end
      if (cmd_i.clr_col) begin
        c_q <= '0;
      end else if (cmd_i.next_col) begin
        c_q <= c_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      found_q <= cmd_i.emit_found;
      row_q   <= cmd_i.emit_found ? msps_pkg::IDX_W'(r_q) : '0;
      col_q   <= cmd_i.emit_found ? msps_pkg::IDX_W'(c_q) : '0;
    end
  end

  assign status_o.last_elem = (cnt_next >= target);
  assign status_o.scan_done = !issue && !rd_valid_q;
  assign status_o.is_saddle = (v_q == rmax_q) && (v_q == cmin_q);
  assign status_o.last_col  = ((c_q + CW'(1)) == cols_q);
  assign status_o.last_row  = ((r_q + RW'(1)) == rows_q);
  assign status_o.slot_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign row_index_o = row_q;
  assign col_index_o = col_q;

endmodule

/* rtl/matrix_saddle_point_search_core.sv */
// Channel   Handshake              Payload
// cfg       cfg_we_i               cfg_idx_i, cfg_data_i
// in        in_valid_i/in_stall_o  element_i
// out       out_valid_o/out_stall_i found_o, row_index_o, col_index_o
//
// Loading takes one element per cycle; the matrix sits in a RAM with a
// write port and a read port. The search walks that RAM one read a cycle:
// for each row a scan for the row maximum, then for each column a scan
// for its minimum and the check, until a saddle point is found or all are done.
// Reset clears control and sets the dimension registers to max rows, max cols.
// in_stall_o is high during the search; a stalled result holds the block
// only when the next result is ready to be written.
module matrix_saddle_point_search_core #(
  parameter int MAX_ROWS = msps_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = msps_pkg::MAX_COLS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [msps_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [msps_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [msps_pkg::DATA_W-1:0] element_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               found_o,
  output logic [msps_pkg::IDX_W-1:0]         row_index_o,
  output logic [msps_pkg::IDX_W-1:0]         col_index_o
);

  msps_pkg::ctrl_cmd_t  cmd;
  msps_pkg::dp_status_t status;

  msps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  msps_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .element_i   (element_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .found_o     (found_o),
    .row_index_o (row_index_o),
    .col_index_o (col_index_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

/* rtl/msps_checker.sv */
module msps_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic                               found_o,
  input logic [msps_pkg::IDX_W-1:0]         row_index_o,
  input logic [msps_pkg::IDX_W-1:0]         col_index_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(found_o) &&
      $stable(row_index_o) && $stable(col_index_o))
    else $error("result beat changed while stalled");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> row_index_o == '0 && col_index_o == '0)
    else $error("no-saddle result carries nonzero indices");

  a_emit_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while input side was open");

  a_search_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result right after an input beat");

endmodule

bind matrix_saddle_point_search_core msps_checker u_msps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .found_o     (found_o),
  .row_index_o (row_index_o),
  .col_index_o (col_index_o)
);
